// ===== hdl/opld_pkg.sv =====
// opld_pkg: shared types and constants of the output phase loss detector
// no dependencies; imported by every module of the block but opld_fifo

package opld_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_ERR_LIMIT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT = 1'd1;

	// opcodes
	localparam logic OP_RUN    = 1'b0;
	localparam logic OP_REINIT = 1'b1;

	// fault codes
	localparam logic [2:0] FAULT_NONE  = 3'd0;
	localparam logic [2:0] FAULT_U     = 3'd1;
	localparam logic [2:0] FAULT_V     = 3'd2;
	localparam logic [2:0] FAULT_W     = 3'd3;
	localparam logic [2:0] FAULT_MULTI = 3'd4;

	// detector constants
	localparam logic [12:0]        DELAY_TICKS = 13'd5000;
	localparam logic signed [15:0] ZERO_BAND   = 16'sd720;
	localparam logic [14:0]        SAT15       = 15'h7FFF;
	localparam logic [7:0]         THR_SCALE   = 8'd144;
	localparam logic [6:0]         FILT_KEEP   = 7'd99;
	// floor(x/100) = (x * RECIP_100) >> 37, exact for 32-bit x
	localparam logic [31:0]        RECIP_100   = 32'h51EB851F;
	localparam int                 RECIP_100_SH = 37;
	// floor(x/5) = (x * RECIP_5) >> 34, exact for 32-bit x
	localparam logic [31:0]        RECIP_5     = 32'hCCCCCCCD;
	localparam int                 RECIP_5_SH  = 34;

	// one input item as seen at the ports
	typedef struct packed {
		logic               opcode;
		logic signed [15:0] d_ref;
		logic signed [15:0] q_ref;
		logic signed [15:0] cos_a;
		logic signed [15:0] sin_a;
		logic signed [15:0] alpha;
		logic signed [15:0] beta;
		logic signed [15:0] ph_u;
		logic signed [15:0] ph_v;
		logic signed [15:0] ph_w;
		logic               sto;
	} tick_t;

	// classified item passed from front to back
	typedef struct packed {
		logic        opcode;
		logic [14:0] err;
		logic [2:0]  zero;
		logic        sto;
	} entry_t;

	// one result item
	typedef struct packed {
		logic        trip;
		logic [2:0]  fault_code;
		logic        fault_latched;
		logic [14:0] filtered_error;
		logic [15:0] error_count;
	} result_t;

endpackage

// ===== hdl/opld_fifo.sv =====
// opld_fifo: small register queue with push/pop handshake
// depends on nothing; used between front and back and for results

module opld_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/opld_front.sv =====
// opld_front: accepts items, rotates the reference and forms the error magnitude
// depends on opld_pkg; three pipeline stages feeding the item queue

module opld_front
	import opld_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	output logic   full,
	input  tick_t  tick,
	output logic   entry_valid,
	input  logic   entry_ready,
	output entry_t entry
);

	function automatic logic signed [15:0] clamp15(input logic signed [17:0] v);
		if (v >= 18'sd32767) begin
			return 16'sd32767;
		end else if (v <= -18'sd32767) begin
			return -16'sd32767;
		end else begin
			return v[15:0];
		end
	endfunction

	logic adv1, adv2, adv3, accept;

	// stage 1: products
	logic               v_s1, op_s1, sto_s1;
	logic signed [31:0] dc_s1, qs_s1, ds_s1, qc_s1;
	logic signed [15:0] ia_s1, ib_s1;
	logic [2:0]         zero_s1;

	// stage 2: rotated and clamped reference
	logic               v_s2, op_s2, sto_s2;
	logic signed [15:0] aref_s2, bref_s2, ia_s2, ib_s2;
	logic [2:0]         zero_s2;

	// stage 3: classified item
	logic   v_s3;
	entry_t entry_s3;

	logic signed [32:0] a_sum, b_sum;
	logic signed [16:0] da, db;
	logic [16:0]        abs_a, abs_b;
	logic [17:0]        esum;
	logic [2:0]         zero_in;

	assign adv3   = !v_s3 || entry_ready;
	assign adv2   = !v_s2 || adv3;
	assign adv1   = !v_s1 || adv2;
	assign full   = !adv1;
	assign accept = push && adv1;

	assign entry_valid = v_s3;
	assign entry       = entry_s3;

	assign zero_in[0] = (tick.ph_u < ZERO_BAND) && (tick.ph_u > -ZERO_BAND);
	assign zero_in[1] = (tick.ph_v < ZERO_BAND) && (tick.ph_v > -ZERO_BAND);
	assign zero_in[2] = (tick.ph_w < ZERO_BAND) && (tick.ph_w > -ZERO_BAND);

	// floor division by 32768 is the top bits of the sum
	assign a_sum = 33'(dc_s1) - 33'(qs_s1);
	assign b_sum = 33'(ds_s1) + 33'(qc_s1);

	assign da    = 17'(aref_s2) - 17'(ia_s2);
	assign db    = 17'(bref_s2) - 17'(ib_s2);
	assign abs_a = da[16] ? 17'(-da) : 17'(da);
	assign abs_b = db[16] ? 17'(-db) : 17'(db);
	assign esum  = {1'b0, abs_a} + {1'b0, abs_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= accept;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			op_s1   <= tick.opcode;
			sto_s1  <= tick.sto;
			dc_s1   <= tick.d_ref * tick.cos_a;
			qs_s1   <= tick.q_ref * tick.sin_a;
			ds_s1   <= tick.d_ref * tick.sin_a;
			qc_s1   <= tick.q_ref * tick.cos_a;
			ia_s1   <= tick.alpha;
			ib_s1   <= tick.beta;
			zero_s1 <= zero_in;
		end
		if (adv2) begin
			op_s2   <= op_s1;
			sto_s2  <= sto_s1;
			aref_s2 <= clamp15(a_sum[32:15]);
			bref_s2 <= clamp15(b_sum[32:15]);
			ia_s2   <= ia_s1;
			ib_s2   <= ib_s1;
			zero_s2 <= zero_s1;
		end
		if (adv3) begin
			entry_s3.opcode <= op_s2;
			entry_s3.sto    <= sto_s2;
			entry_s3.zero   <= zero_s2;
			entry_s3.err    <= (esum > {3'd0, SAT15}) ? SAT15 : esum[14:0];
		end
	end

endmodule

// ===== hdl/opld_back.sv =====
// opld_back: configuration registers, error filter and trip logic
// depends on opld_pkg; takes classified items from the queue one at a time through the idle, multiply and update states

module opld_back
	import opld_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  entry_t                entry,
	input  logic                  entry_empty,
	output logic                  entry_pop,
	output result_t               res,
	output logic                  res_push,
	input  logic                  res_full
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0] state_q;

	// configuration and derived thresholds
	logic [14:0] setting_q;
	logic [15:0] limit_q;
	logic [22:0] thr_mul_q;
	logic [54:0] thr_prod_q;
	logic [49:0] level_prod_q;
	logic [15:0] thr, level;

	// item in flight
	entry_t      cur_q;
	logic [21:0] sum_q;
	logic [53:0] prod_q;

	// detector state
	logic [12:0] delay_q, delay_nx;
	logic [14:0] filt_q, filt_nx;
	logic [15:0] cnt_q, cnt_nx;
	logic [15:0] zc_q [3];
	logic [15:0] zc_nx [3];
	logic [2:0]  flags_q, flags_nx;
	logic        latch_q, latch_nx;

	logic        counting, hit, trip_nx, commit;
	logic [16:0] cnt_inc;
	logic [1:0]  nz;
	logic [2:0]  code_nx;

	assign thr   = thr_prod_q[52:RECIP_100_SH];
	assign level = level_prod_q[49:RECIP_5_SH];

	assign entry_pop = (state_q == ST_IDLE) && !entry_empty;
	assign commit    = (state_q == ST_UPD) && !res_full;
	assign res_push  = commit;

	always_comb begin
		filt_nx  = prod_q[51:RECIP_100_SH];
		delay_nx = (delay_q < DELAY_TICKS) ? delay_q + 13'd1 : delay_q;
		counting = ({1'b0, filt_nx} >= thr) && (delay_nx == DELAY_TICKS) &&
		           (setting_q != '0);
		cnt_inc  = {1'b0, cnt_q} + 17'd1;
		hit      = cnt_inc >= {1'b0, limit_q};
		nz       = {1'b0, flags_q[0]} + {1'b0, flags_q[1]} + {1'b0, flags_q[2]};
		cnt_nx   = '0;
		latch_nx = latch_q;
		code_nx  = FAULT_NONE;
		trip_nx  = 1'b0;
		flags_nx = '0;
		for (int i = 0; i < 3; i++) begin
			zc_nx[i] = '0;
		end
		if (counting) begin
			cnt_nx = cnt_inc[15:0];
			if (hit) begin
				cnt_nx   = limit_q;
				latch_nx = 1'b1;
				// flags from before this item decide the code
				if (!cur_q.sto) begin
					if (nz == 2'd0) begin
						cnt_nx = '0;
					end else if (nz == 2'd1) begin
						if (flags_q[0]) begin
							code_nx = FAULT_U;
						end else if (flags_q[1]) begin
							code_nx = FAULT_V;
						end else begin
							code_nx = FAULT_W;
						end
					end else begin
						code_nx = FAULT_MULTI;
					end
				end
				trip_nx = (cnt_nx != '0);
			end
			for (int i = 0; i < 3; i++) begin
				if (cur_q.zero[i]) begin
					zc_nx[i]    = (zc_q[i] != 16'hFFFF) ? zc_q[i] + 16'd1 : zc_q[i];
					flags_nx[i] = flags_q[i] | (zc_nx[i] > level);
				end
			end
		end
		if (cur_q.opcode == OP_REINIT) begin
			delay_nx = '0;
			filt_nx  = '0;
			cnt_nx   = '0;
			latch_nx = 1'b0;
			code_nx  = FAULT_NONE;
			trip_nx  = 1'b0;
			flags_nx = '0;
			for (int i = 0; i < 3; i++) begin
				zc_nx[i] = '0;
			end
		end
	end

	assign res.trip           = trip_nx;
	assign res.fault_code     = code_nx;
	assign res.fault_latched  = latch_nx;
	assign res.filtered_error = filt_nx;
	assign res.error_count    = cnt_nx;

	// threshold and hold level follow the registers through the registered products thr_mul_q, thr_prod_q and level_prod_q
	always_ff @(posedge clk) begin
		thr_mul_q    <= {8'd0, setting_q} * {15'd0, THR_SCALE};
		thr_prod_q   <= {32'd0, thr_mul_q} * {23'd0, RECIP_100};
		level_prod_q <= {32'd0, limit_q, 2'b00} * {18'd0, RECIP_5};
	end

	always_ff @(posedge clk) begin
		if (entry_pop) begin
			cur_q <= entry;
			sum_q <= {7'd0, filt_q} * {15'd0, FILT_KEEP} + {7'd0, entry.err};
		end
		if (state_q == ST_MUL) begin
			prod_q <= {32'd0, sum_q} * {22'd0, RECIP_100};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			setting_q <= '0;
			limit_q   <= '0;
			delay_q   <= '0;
			filt_q    <= '0;
			cnt_q     <= '0;
			flags_q   <= '0;
			latch_q   <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				zc_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_ERR_LIMIT: setting_q <= cfg_wdata[14:0];
					REG_COUNT_LIMIT: limit_q <= cfg_wdata;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (!entry_empty) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (commit) begin
						state_q <= ST_IDLE;
						delay_q <= delay_nx;
						filt_q  <= filt_nx;
						cnt_q   <= cnt_nx;
						flags_q <= flags_nx;
						latch_q <= latch_nx;
						for (int i = 0; i < 3; i++) begin
							zc_q[i] <= zc_nx[i];
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/output_phase_loss_detector.sv =====
// output_phase_loss_detector: an accepted item passes 3 front stages, the item queue and the
// back sequencer (idle, multiply, update) on its way to the result queue and the ports.
// back part: no new item until the last one commits, which waits on a full result queue;
// the front takes items on consecutive cycles until the item queue fills.
// reset: arst_n clears both registers, all detector state and every queue at once.

module output_phase_loss_detector
	import opld_pkg::*;
#(
	parameter int QUEUE_DEPTH  = 4,
	parameter int RESULT_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  opcode,
	input  logic signed [15:0]    d_current_ref,
	input  logic signed [15:0]    q_current_ref,
	input  logic signed [15:0]    cos_angle,
	input  logic signed [15:0]    sin_angle,
	input  logic signed [15:0]    alpha_current_meas,
	input  logic signed [15:0]    beta_current_meas,
	input  logic signed [15:0]    phase_u_current,
	input  logic signed [15:0]    phase_v_current,
	input  logic signed [15:0]    phase_w_current,
	input  logic                  safe_torque_off_active,
	output logic                  empty,
	input  logic                  pop,
	output logic                  trip,
	output logic [2:0]            fault_code,
	output logic                  fault_latched,
	output logic [14:0]           filtered_error,
	output logic [15:0]           error_count,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	tick_t   tick;
	entry_t  fr_entry, q_entry;
	logic    fr_valid, q_full, q_empty, q_pop;
	result_t bk_res, out_res;
	logic    bk_push, r_full;

	assign tick.opcode = opcode;
	assign tick.d_ref  = d_current_ref;
	assign tick.q_ref  = q_current_ref;
	assign tick.cos_a  = cos_angle;
	assign tick.sin_a  = sin_angle;
	assign tick.alpha  = alpha_current_meas;
	assign tick.beta   = beta_current_meas;
	assign tick.ph_u   = phase_u_current;
	assign tick.ph_v   = phase_v_current;
	assign tick.ph_w   = phase_w_current;
	assign tick.sto    = safe_torque_off_active;

	opld_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.tick        (tick),
		.entry_valid (fr_valid),
		.entry_ready (!q_full),
		.entry       (fr_entry)
	);

	opld_fifo #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_item_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fr_valid),
		.wr_data (fr_entry),
		.rd_en   (q_pop),
		.rd_data (q_entry),
		.full    (q_full),
		.empty   (q_empty)
	);

	opld_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.entry       (q_entry),
		.entry_empty (q_empty),
		.entry_pop   (q_pop),
		.res         (bk_res),
		.res_push    (bk_push),
		.res_full    (r_full)
	);

	opld_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RESULT_DEPTH)
	) u_result_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (bk_push),
		.wr_data (bk_res),
		.rd_en   (pop),
		.rd_data (out_res),
		.full    (r_full),
		.empty   (empty)
	);

	assign trip           = out_res.trip;
	assign fault_code     = out_res.fault_code;
	assign fault_latched  = out_res.fault_latched;
	assign filtered_error = out_res.filtered_error;
	assign error_count    = out_res.error_count;

endmodule

// ===== hdl/opld_checker.sv =====
// opld_checker: port-level properties of the output phase loss detector
// depends on opld_pkg; bound to output_phase_loss_detector below

module opld_checker
	import opld_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        trip,
	input logic [2:0]  fault_code,
	input logic        fault_latched,
	input logic [14:0] filtered_error,
	input logic [15:0] error_count
);

	// a trip always comes with the latch set and a nonzero count
	a_trip_latched: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && trip |-> fault_latched && (error_count != '0))
		else $error("trip without latch or count");

	// a phase code is only reported once the count limit was reached
	a_code_latched: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (fault_code != FAULT_NONE) |-> fault_latched)
		else $error("fault code without latch");

	// a waiting item holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(filtered_error) && $stable(error_count) &&
		$stable(trip) && $stable(fault_code))
		else $error("result changed while stalled");

endmodule

bind output_phase_loss_detector opld_checker u_opld_checker (.*);
